FILE: sv/rtbc_pkg.sv
// ----------------------------------------------------------------------------
// Region tint and bounds checker package
// Shared constants, codes and types for the region checker modules.
// ----------------------------------------------------------------------------
package rtbc_pkg;

    // Default coordinate width in bits.
    localparam int COORD_BITS = 12;

    // Depth of the queue between the classifier and the accumulator.
    localparam int QUEUE_DEPTH = 4;

    // Width of an RGBA8 color word.
    localparam int COLOR_BITS = 32;

    // Width of the configuration port.
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    // Width of the output tuser: finding code plus box and color flags.
    localparam int OUT_USER_BITS = 5;

    // Result codes.
    typedef enum logic [2:0] {
        FND_HELD        = 3'd0,
        FND_NO_TINT     = 3'd1,
        FND_NOTHING     = 3'd2,
        FND_BOUNDS      = 3'd3,
        FND_TINT_ABSENT = 3'd4,
        FND_FOREIGN     = 3'd5
    } t_finding;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CHECK_MODE    = 3'd0,
        CFG_GROUND_COLOR  = 3'd1,
        CFG_TINT_COLOR    = 3'd2,
        CFG_TINT_PRESENT  = 3'd3,
        CFG_EXPECT_LEFT   = 3'd4,
        CFG_EXPECT_TOP    = 3'd5,
        CFG_EXPECT_RIGHT  = 3'd6,
        CFG_EXPECT_BOTTOM = 3'd7
    } t_cfg_idx;

    // Classification of one pixel, produced by the front end.
    typedef struct packed {
        logic last;      // final pixel of the region
        logic painted;   // differs from the ground color
        logic blend_ok;  // every channel between ground and tint
        logic is_tint;   // equals the tint color exactly
    } t_cls;

    localparam int CLS_BITS = $bits(t_cls);

endpackage

FILE: sv/region_tint_and_bounds_checker.sv
// ----------------------------------------------------------------------------
// Region tint and bounds checker
// Checks the painted pixels of one region against an expected rectangle or
// against a ground-to-tint color blend.
// ----------------------------------------------------------------------------
// Usage:
// Pixels arrive on the s-side stream, one per transaction, with tlast on the
// region's final pixel. Painted pixels widen a bounding box; in tint mode they
// are also checked channel by channel against the ground-to-tint interval.
// One result transaction per region leaves on the m-side stream.
// The user writes registers through the cfg channel only while no region is
// in flight; the block does not enforce it. Throughput is one pixel per clock
// unless results stall, set by the back-end box and color update. A result
// passes the classify register and queue and is held in the output register.
// When the receiver stalls, pixels without tlast keep flowing; the next last
// pixel waits at the head of the queue, and o_s_tready drops once the queue
// and the classify register hold four more pixels behind it.
// Synchronous active-low reset clears the configuration, the region state and
// the queue; no result is pending afterward.
// ----------------------------------------------------------------------------
module region_tint_and_bounds_checker #(
    parameter int COORD_BITS = rtbc_pkg::COORD_BITS
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // Pixel stream
    input  logic                                     i_s_tvalid,
    output logic                                     o_s_tready,
    // tdata: pixel_x, pixel_y, red, green, blue, alpha (zero fill above)
    input  logic [((2*COORD_BITS+32+7)/8)*8-1:0]     i_s_tdata,
    input  logic                                     i_s_tlast,
    // Result stream
    output logic                                     o_m_tvalid,
    input  logic                                     i_m_tready,
    // tdata: found_left, found_top, found_right, found_bottom, found_color
    output logic [((4*COORD_BITS+34+7)/8)*8-1:0]     o_m_tdata,
    // tuser: finding, box_valid, color_valid
    output logic [rtbc_pkg::OUT_USER_BITS-1:0]       o_m_tuser,
    // Configuration write channel
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [rtbc_pkg::CFG_IDX_BITS-1:0]        i_cfg_index,
    input  logic [rtbc_pkg::CFG_DATA_BITS-1:0]       i_cfg_data
);

    localparam int IN_W  = ((2*COORD_BITS + 32 + 7) / 8) * 8;
    localparam int OUT_W = ((4*COORD_BITS + 34 + 7) / 8) * 8;
    localparam int Q_W   = rtbc_pkg::CLS_BITS + 2*COORD_BITS + rtbc_pkg::COLOR_BITS;

    // Configuration registers.
    logic                            r_check_mode;
    logic [rtbc_pkg::COLOR_BITS-1:0] r_ground_color;
    logic [rtbc_pkg::COLOR_BITS-1:0] r_tint_color;
    logic                            r_tint_present;
    logic [COORD_BITS-1:0]           r_expect_left;
    logic [COORD_BITS-1:0]           r_expect_top;
    logic [COORD_BITS:0]             r_expect_right;
    logic [COORD_BITS:0]             r_expect_bottom;

    // Front end to queue.
    logic                            f_valid;
    logic                            f_ready;
    rtbc_pkg::t_cls                  f_cls;
    logic [COORD_BITS-1:0]           f_x;
    logic [COORD_BITS-1:0]           f_y;
    logic [rtbc_pkg::COLOR_BITS-1:0] f_rgba;

    // Queue to back end.
    logic                            q_valid;
    logic                            q_ready;
    logic [Q_W-1:0]                  q_data;
    rtbc_pkg::t_cls                  q_cls;
    logic [COORD_BITS-1:0]           q_x;
    logic [COORD_BITS-1:0]           q_y;
    logic [rtbc_pkg::COLOR_BITS-1:0] q_rgba;

    // Register writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_mode    <= 1'b0;
            r_ground_color  <= '0;
            r_tint_color    <= '0;
            r_tint_present  <= 1'b0;
            r_expect_left   <= '0;
            r_expect_top    <= '0;
            r_expect_right  <= '0;
            r_expect_bottom <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (rtbc_pkg::t_cfg_idx'(i_cfg_index))
                rtbc_pkg::CFG_CHECK_MODE:    r_check_mode    <= i_cfg_data[0];
                rtbc_pkg::CFG_GROUND_COLOR:  r_ground_color  <= i_cfg_data;
                rtbc_pkg::CFG_TINT_COLOR:    r_tint_color    <= i_cfg_data;
                rtbc_pkg::CFG_TINT_PRESENT:  r_tint_present  <= i_cfg_data[0];
                rtbc_pkg::CFG_EXPECT_LEFT:   r_expect_left   <= i_cfg_data[COORD_BITS-1:0];
                rtbc_pkg::CFG_EXPECT_TOP:    r_expect_top    <= i_cfg_data[COORD_BITS-1:0];
                rtbc_pkg::CFG_EXPECT_RIGHT:  r_expect_right  <= i_cfg_data[COORD_BITS:0];
                rtbc_pkg::CFG_EXPECT_BOTTOM: r_expect_bottom <= i_cfg_data[COORD_BITS:0];
                default: ;
            endcase
        end
    end

    // Accept and classify pixels.
    rtbc_front #(
        .COORD_BITS (COORD_BITS),
        .IN_W       (IN_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_tvalid),
        .o_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .i_s_tlast      (i_s_tlast),
        .i_ground_color (r_ground_color),
        .i_tint_color   (r_tint_color),
        .o_valid        (f_valid),
        .i_ready        (f_ready),
        .o_cls          (f_cls),
        .o_x            (f_x),
        .o_y            (f_y),
        .o_rgba         (f_rgba)
    );

    // Decouple classification from accumulation.
    rtbc_queue #(
        .WIDTH (Q_W),
        .DEPTH (rtbc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  ({f_cls, f_x, f_y, f_rgba}),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_data)
    );

    assign q_rgba = q_data[rtbc_pkg::COLOR_BITS-1:0];
    assign q_y    = q_data[rtbc_pkg::COLOR_BITS +: COORD_BITS];
    assign q_x    = q_data[rtbc_pkg::COLOR_BITS + COORD_BITS +: COORD_BITS];
    assign q_cls  = rtbc_pkg::t_cls'(q_data[Q_W-1 -: rtbc_pkg::CLS_BITS]);

    // Accumulate the region and form results.
    rtbc_back #(
        .COORD_BITS (COORD_BITS),
        .OUT_W      (OUT_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .o_ready         (q_ready),
        .i_cls           (q_cls),
        .i_x             (q_x),
        .i_y             (q_y),
        .i_rgba          (q_rgba),
        .i_check_mode    (r_check_mode),
        .i_tint_present  (r_tint_present),
        .i_expect_left   (r_expect_left),
        .i_expect_top    (r_expect_top),
        .i_expect_right  (r_expect_right),
        .i_expect_bottom (r_expect_bottom),
        .o_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .o_m_tdata       (o_m_tdata),
        .o_m_tuser       (o_m_tuser)
    );

`ifndef ASSERT_OFF
    // A foreign color result always carries both a box and a color.
    a_foreign_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[2:0] == rtbc_pkg::FND_FOREIGN)
        |-> (o_m_tuser[3] && o_m_tuser[4]))
        else $error("foreign result without box or color");

    // Results without a measured rectangle carry no box and no color.
    a_empty_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser[2:0] == rtbc_pkg::FND_NO_TINT
                        || o_m_tuser[2:0] == rtbc_pkg::FND_NOTHING))
        |-> (!o_m_tuser[3] && !o_m_tuser[4]))
        else $error("empty result with box or color flag");

    // Only a foreign color result reports a color.
    a_color_only_foreign : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[4]) |-> (o_m_tuser[2:0] == rtbc_pkg::FND_FOREIGN))
        else $error("color reported on a non-foreign result");

    // A last pixel never leaves the queue while a stalled result occupies the slot.
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && q_ready && q_cls.last) |-> (!o_m_tvalid || i_m_tready))
        else $error("result register overwritten while stalled");
`endif

endmodule

FILE: sv/rtbc_front.sv
// ----------------------------------------------------------------------------
// Region checker front end
// Accepts pixels, classifies them against ground and tint, and registers the
// classified pixel for the queue.
// ----------------------------------------------------------------------------
module rtbc_front #(
    parameter int COORD_BITS = rtbc_pkg::COORD_BITS,
    parameter int IN_W       = 56
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Pixel stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [IN_W-1:0]                  i_s_tdata,
    input  logic                             i_s_tlast,
    // Color configuration
    input  logic [rtbc_pkg::COLOR_BITS-1:0]  i_ground_color,
    input  logic [rtbc_pkg::COLOR_BITS-1:0]  i_tint_color,
    // Classified pixel toward the queue
    output logic                             o_valid,
    input  logic                             i_ready,
    output rtbc_pkg::t_cls                   o_cls,
    output logic [COORD_BITS-1:0]            o_x,
    output logic [COORD_BITS-1:0]            o_y,
    output logic [rtbc_pkg::COLOR_BITS-1:0]  o_rgba
);

    logic                            r_valid;
    logic                            n_valid;
    rtbc_pkg::t_cls                  r_cls;
    logic [COORD_BITS-1:0]           r_x;
    logic [COORD_BITS-1:0]           r_y;
    logic [rtbc_pkg::COLOR_BITS-1:0] r_rgba;

    logic                            accept;
    logic [COORD_BITS-1:0]           px_x;
    logic [COORD_BITS-1:0]           px_y;
    logic [rtbc_pkg::COLOR_BITS-1:0] px_rgba;
    logic [3:0]                      chan_ok;
    rtbc_pkg::t_cls                  cls;

    // Unpack the transaction.
    assign px_x    = i_s_tdata[COORD_BITS-1:0];
    assign px_y    = i_s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign px_rgba = i_s_tdata[2*COORD_BITS+rtbc_pkg::COLOR_BITS-1:2*COORD_BITS];

    // Each channel must lie in the closed interval spanned by ground and tint.
    always_comb begin
        logic [7:0] v;
        logic [7:0] g;
        logic [7:0] t;
        logic [7:0] lo;
        logic [7:0] hi;
        for (int k = 0; k < 4; k++) begin
            v = px_rgba[8*k +: 8];
            g = i_ground_color[8*k +: 8];
            t = i_tint_color[8*k +: 8];
            lo = (g < t) ? g : t;
            hi = (g < t) ? t : g;
            chan_ok[k] = (v >= lo) && (v <= hi);
        end
    end

    always_comb begin
        cls.last     = i_s_tlast;
        cls.painted  = (px_rgba != i_ground_color);
        cls.blend_ok = &chan_ok;
        cls.is_tint  = (px_rgba == i_tint_color);
    end

    // The stage takes a new pixel whenever it is empty or being drained.
    assign o_s_tready = !r_valid || i_ready;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cls  <= cls;
            r_x    <= px_x;
            r_y    <= px_y;
            r_rgba <= px_rgba;
        end
    end

    assign o_valid = r_valid;
    assign o_cls   = r_cls;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_rgba  = r_rgba;

endmodule

FILE: sv/rtbc_queue.sv
// ----------------------------------------------------------------------------
// Region checker queue
// Small first-in first-out buffer between the front end and the accumulator.
// ----------------------------------------------------------------------------
module rtbc_queue #(
    parameter int WIDTH = 60,
    parameter int DEPTH = rtbc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [PTR_BITS-1:0] n_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count != CNT_BITS'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd_ptr];

    // Pointer and fill bookkeeping.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage entries need no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

FILE: sv/rtbc_back.sv
// ----------------------------------------------------------------------------
// Region checker back end
// Accumulates the bounding box, tint and foreign pixel state of a region and
// forms the result in an output register on the region's last pixel.
// ----------------------------------------------------------------------------
module rtbc_back #(
    parameter int COORD_BITS = rtbc_pkg::COORD_BITS,
    parameter int OUT_W      = 88
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Classified pixel from the queue
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  rtbc_pkg::t_cls                       i_cls,
    input  logic [COORD_BITS-1:0]                i_x,
    input  logic [COORD_BITS-1:0]                i_y,
    input  logic [rtbc_pkg::COLOR_BITS-1:0]      i_rgba,
    // Check configuration
    input  logic                                 i_check_mode,
    input  logic                                 i_tint_present,
    input  logic [COORD_BITS-1:0]                i_expect_left,
    input  logic [COORD_BITS-1:0]                i_expect_top,
    input  logic [COORD_BITS:0]                  i_expect_right,
    input  logic [COORD_BITS:0]                  i_expect_bottom,
    // Result stream
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [OUT_W-1:0]                     o_m_tdata,
    output logic [rtbc_pkg::OUT_USER_BITS-1:0]   o_m_tuser
);

    // Region state.
    logic                            r_inked,     n_inked,     u_inked;
    logic [COORD_BITS-1:0]           r_left,      n_left,      u_left;
    logic [COORD_BITS-1:0]           r_top,       n_top,       u_top;
    logic [COORD_BITS:0]             r_right,     n_right,     u_right;
    logic [COORD_BITS:0]             r_bottom,    n_bottom,    u_bottom;
    logic                            r_tint_seen, n_tint_seen, u_tint_seen;
    logic                            r_fgn_seen,  n_fgn_seen,  u_fgn_seen;
    logic [COORD_BITS-1:0]           r_fgn_x,     n_fgn_x,     u_fgn_x;
    logic [COORD_BITS-1:0]           r_fgn_y,     n_fgn_y,     u_fgn_y;
    logic [rtbc_pkg::COLOR_BITS-1:0] r_fgn_rgba,  n_fgn_rgba,  u_fgn_rgba;

    // Output register.
    logic                            r_out_valid;
    logic                            n_out_valid;
    rtbc_pkg::t_finding              r_finding,   n_finding;
    logic                            r_box_valid, n_box_valid;
    logic [COORD_BITS-1:0]           r_fl,        n_fl;
    logic [COORD_BITS-1:0]           r_ft,        n_ft;
    logic [COORD_BITS:0]             r_fr,        n_fr;
    logic [COORD_BITS:0]             r_fb,        n_fb;
    logic                            r_col_valid, n_col_valid;
    logic [rtbc_pkg::COLOR_BITS-1:0] r_fc,        n_fc;

    logic                            slot_free;
    logic                            take;
    logic                            close;
    logic [COORD_BITS:0]             x1;
    logic [COORD_BITS:0]             y1;
    logic [COORD_BITS:0]             fgn_x1;
    logic [COORD_BITS:0]             fgn_y1;

    // A last pixel needs room in the output register; others always pass.
    assign slot_free = !r_out_valid || i_m_tready;
    assign o_ready   = !i_cls.last || slot_free;
    assign take      = i_valid && o_ready;
    assign close     = take && i_cls.last;

    assign x1 = {1'b0, i_x} + 1'b1;
    assign y1 = {1'b0, i_y} + 1'b1;

    // Fold the pixel into the region state.
    always_comb begin
        u_inked     = r_inked;
        u_left      = r_left;
        u_top       = r_top;
        u_right     = r_right;
        u_bottom    = r_bottom;
        u_tint_seen = r_tint_seen;
        u_fgn_seen  = r_fgn_seen;
        u_fgn_x     = r_fgn_x;
        u_fgn_y     = r_fgn_y;
        u_fgn_rgba  = r_fgn_rgba;
        if (take && i_cls.painted) begin
            if (!i_cls.blend_ok && !r_fgn_seen) begin
                u_fgn_seen = 1'b1;
                u_fgn_x    = i_x;
                u_fgn_y    = i_y;
                u_fgn_rgba = i_rgba;
            end
            if (!r_inked) begin
                u_inked  = 1'b1;
                u_left   = i_x;
                u_top    = i_y;
                u_right  = x1;
                u_bottom = y1;
            end else begin
                if (i_x < r_left)   u_left   = i_x;
                if (i_y < r_top)    u_top    = i_y;
                if (x1 > r_right)   u_right  = x1;
                if (y1 > r_bottom)  u_bottom = y1;
            end
            if (i_cls.is_tint) begin
                u_tint_seen = 1'b1;
            end
        end
    end

    // The region state clears once its result is formed.
    always_comb begin
        if (close) begin
            n_inked     = 1'b0;
            n_left      = '0;
            n_top       = '0;
            n_right     = '0;
            n_bottom    = '0;
            n_tint_seen = 1'b0;
            n_fgn_seen  = 1'b0;
            n_fgn_x     = '0;
            n_fgn_y     = '0;
            n_fgn_rgba  = '0;
        end else begin
            n_inked     = u_inked;
            n_left      = u_left;
            n_top       = u_top;
            n_right     = u_right;
            n_bottom    = u_bottom;
            n_tint_seen = u_tint_seen;
            n_fgn_seen  = u_fgn_seen;
            n_fgn_x     = u_fgn_x;
            n_fgn_y     = u_fgn_y;
            n_fgn_rgba  = u_fgn_rgba;
        end
    end

    assign fgn_x1 = {1'b0, u_fgn_x} + 1'b1;
    assign fgn_y1 = {1'b0, u_fgn_y} + 1'b1;

    // Result selection; order of the checks decides the finding.
    always_comb begin
        n_finding   = rtbc_pkg::FND_HELD;
        n_box_valid = 1'b0;
        n_fl        = '0;
        n_ft        = '0;
        n_fr        = '0;
        n_fb        = '0;
        n_col_valid = 1'b0;
        n_fc        = '0;
        if (i_check_mode) begin
            priority if (!i_tint_present) begin
                n_finding = rtbc_pkg::FND_NO_TINT;
            end else if (u_fgn_seen) begin
                n_finding   = rtbc_pkg::FND_FOREIGN;
                n_box_valid = 1'b1;
                n_col_valid = 1'b1;
                n_fl        = u_fgn_x;
                n_ft        = u_fgn_y;
                n_fr        = fgn_x1;
                n_fb        = fgn_y1;
                n_fc        = u_fgn_rgba;
            end else if (!u_inked) begin
                n_finding = rtbc_pkg::FND_NOTHING;
            end else begin
                n_box_valid = 1'b1;
                n_fl        = u_left;
                n_ft        = u_top;
                n_fr        = u_right;
                n_fb        = u_bottom;
                n_finding   = u_tint_seen ? rtbc_pkg::FND_HELD : rtbc_pkg::FND_TINT_ABSENT;
            end
        end else begin
            if (!u_inked) begin
                n_finding = rtbc_pkg::FND_NOTHING;
            end else begin
                n_box_valid = 1'b1;
                n_fl        = u_left;
                n_ft        = u_top;
                n_fr        = u_right;
                n_fb        = u_bottom;
                n_finding   = (u_left == i_expect_left && u_top == i_expect_top
                               && u_right == i_expect_right
                               && u_bottom == i_expect_bottom)
                              ? rtbc_pkg::FND_HELD : rtbc_pkg::FND_BOUNDS;
            end
        end
    end

    // Output valid: set by a closing pixel, cleared when the result is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (close) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_inked     <= 1'b0;
            r_left      <= '0;
            r_top       <= '0;
            r_right     <= '0;
            r_bottom    <= '0;
            r_tint_seen <= 1'b0;
            r_fgn_seen  <= 1'b0;
            r_fgn_x     <= '0;
            r_fgn_y     <= '0;
            r_fgn_rgba  <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_inked     <= n_inked;
            r_left      <= n_left;
            r_top       <= n_top;
            r_right     <= n_right;
            r_bottom    <= n_bottom;
            r_tint_seen <= n_tint_seen;
            r_fgn_seen  <= n_fgn_seen;
            r_fgn_x     <= n_fgn_x;
            r_fgn_y     <= n_fgn_y;
            r_fgn_rgba  <= n_fgn_rgba;
        end
    end

    // Result payload is loaded only by a closing pixel.
    always_ff @(posedge i_clk) begin
        if (close) begin
            r_finding   <= n_finding;
            r_box_valid <= n_box_valid;
            r_fl        <= n_fl;
            r_ft        <= n_ft;
            r_fr        <= n_fr;
            r_fb        <= n_fb;
            r_col_valid <= n_col_valid;
            r_fc        <= n_fc;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'({r_fc, r_fb, r_fr, r_ft, r_fl});
    assign o_m_tuser  = {r_col_valid, r_box_valid, r_finding};

endmodule

FILE: sim/region_result_checker.sv
// ----------------------------------------------------------------------------
// Region result checker
// Watches the pixel, result and register channels of the region checker,
// keeps its own copy of the registers and of the region state, predicts the
// result of every region and compares each result transaction against it.
// ----------------------------------------------------------------------------
module region_result_checker #(
    parameter int COORD_BITS = rtbc_pkg::COORD_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Pixel stream as seen on the wire
    input  logic                                 i_s_tvalid,
    input  logic                                 i_s_tready,
    input  logic [((2*COORD_BITS+32+7)/8)*8-1:0] i_s_tdata,
    input  logic                                 i_s_tlast,
    // Result stream as seen on the wire
    input  logic                                 i_m_tvalid,
    input  logic                                 i_m_tready,
    input  logic [((4*COORD_BITS+34+7)/8)*8-1:0] i_m_tdata,
    input  logic [rtbc_pkg::OUT_USER_BITS-1:0]   i_m_tuser,
    // Register writes as seen on the wire
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [rtbc_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [rtbc_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // Status for the testbench top
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_results,
    output logic [7:0]                           o_kinds
);

    // One region result, laid out field by field.
    typedef struct packed {
        rtbc_pkg::t_finding      finding;
        logic                    box_valid;
        logic [COORD_BITS-1:0]   left;
        logic [COORD_BITS-1:0]   top;
        logic [COORD_BITS:0]     right;
        logic [COORD_BITS:0]     bottom;
        logic                    color_valid;
        logic [31:0]             color;
    } t_region_verdict;

    // Results still owed by the block, oldest first.
    t_region_verdict verdict_q[$];

    // Register copies.
    logic                  mode_tint;
    logic [31:0]           ground_rgba;
    logic [31:0]           tint_rgba;
    logic                  tint_on;
    logic [COORD_BITS-1:0] want_left;
    logic [COORD_BITS-1:0] want_top;
    logic [COORD_BITS:0]   want_right;
    logic [COORD_BITS:0]   want_bottom;

    // State of the region in progress.
    logic                  inked;
    logic [COORD_BITS-1:0] box_l;
    logic [COORD_BITS-1:0] box_t;
    logic [COORD_BITS:0]   box_r;
    logic [COORD_BITS:0]   box_b;
    logic                  tint_hit;
    logic                  stray_hit;
    logic [COORD_BITS-1:0] stray_x;
    logic [COORD_BITS-1:0] stray_y;
    logic [31:0]           stray_rgba;

    int              fail_count = 0;
    int              results_seen = 0;
    logic [7:0]      kinds_seen = '0;
    t_region_verdict fresh;
    t_region_verdict got;
    t_region_verdict want;

    function automatic void forget_region();
        inked      = 1'b0;
        box_l      = '0;
        box_t      = '0;
        box_r      = '0;
        box_b      = '0;
        tint_hit   = 1'b0;
        stray_hit  = 1'b0;
        stray_x    = '0;
        stray_y    = '0;
        stray_rgba = '0;
    endfunction

    // True when every channel lies in the closed range spanned by ground and tint.
    function automatic logic in_blend(input logic [31:0] rgba);
        logic [7:0] v;
        logic [7:0] g;
        logic [7:0] t;
        logic [7:0] lo;
        logic [7:0] hi;
        logic       ok;
        ok = 1'b1;
        for (int k = 0; k < 4; k++) begin
            v  = rgba[8*k +: 8];
            g  = ground_rgba[8*k +: 8];
            t  = tint_rgba[8*k +: 8];
            lo = (g < t) ? g : t;
            hi = (g < t) ? t : g;
            if (v < lo || v > hi) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    // Folds one pixel into the region state; on the last pixel it returns 1
    // and the region's result.
    function automatic bit take_pixel(input logic [COORD_BITS-1:0] x,
                                      input logic [COORD_BITS-1:0] y,
                                      input logic [31:0] rgba, input logic last,
                                      output t_region_verdict verdict);
        logic [COORD_BITS:0] x_end;
        logic [COORD_BITS:0] y_end;
        x_end   = {1'b0, x} + 1'b1;
        y_end   = {1'b0, y} + 1'b1;
        verdict = '0;
        if (rgba != ground_rgba) begin
            if (!stray_hit && !in_blend(rgba)) begin
                stray_hit  = 1'b1;
                stray_x    = x;
                stray_y    = y;
                stray_rgba = rgba;
            end
            if (!inked) begin
                inked = 1'b1;
                box_l = x;
                box_t = y;
                box_r = x_end;
                box_b = y_end;
            end else begin
                if (x < box_l) box_l = x;
                if (y < box_t) box_t = y;
                if (x_end > box_r) box_r = x_end;
                if (y_end > box_b) box_b = y_end;
            end
            if (rgba == tint_rgba) begin
                tint_hit = 1'b1;
            end
        end
        if (!last) begin
            return 1'b0;
        end
        if (mode_tint) begin
            // Tint check: missing tint, then foreign pixel, then empty region.
            if (!tint_on) begin
                verdict.finding = rtbc_pkg::FND_NO_TINT;
            end else if (stray_hit) begin
                verdict.finding     = rtbc_pkg::FND_FOREIGN;
                verdict.box_valid   = 1'b1;
                verdict.left        = stray_x;
                verdict.top         = stray_y;
                verdict.right       = {1'b0, stray_x} + 1'b1;
                verdict.bottom      = {1'b0, stray_y} + 1'b1;
                verdict.color_valid = 1'b1;
                verdict.color       = stray_rgba;
            end else if (!inked) begin
                verdict.finding = rtbc_pkg::FND_NOTHING;
            end else begin
                verdict.box_valid = 1'b1;
                verdict.left      = box_l;
                verdict.top       = box_t;
                verdict.right     = box_r;
                verdict.bottom    = box_b;
                verdict.finding   = tint_hit ? rtbc_pkg::FND_HELD
                                             : rtbc_pkg::FND_TINT_ABSENT;
            end
        end else begin
            // Bounds check: edge by edge against the expected rectangle.
            if (!inked) begin
                verdict.finding = rtbc_pkg::FND_NOTHING;
            end else begin
                verdict.box_valid = 1'b1;
                verdict.left      = box_l;
                verdict.top       = box_t;
                verdict.right     = box_r;
                verdict.bottom    = box_b;
                if (box_l == want_left && box_t == want_top && box_r == want_right
                        && box_b == want_bottom) begin
                    verdict.finding = rtbc_pkg::FND_HELD;
                end else begin
                    verdict.finding = rtbc_pkg::FND_BOUNDS;
                end
            end
        end
        forget_region();
        return 1'b1;
    endfunction

    function automatic string describe(input t_region_verdict v);
        return $sformatf({"finding=%0d box_valid=%b box=(%0d,%0d,%0d,%0d) ",
                          "color_valid=%b color=%08h"},
                         v.finding, v.box_valid, v.left, v.top, v.right, v.bottom,
                         v.color_valid, v.color);
    endfunction

    task automatic report_result(input bit owed, input t_region_verdict exp_v,
                                 input t_region_verdict act_v);
        fail_count++;
        if (fail_count <= 10) begin
            if (owed) begin
                $display("Mismatch on result %0d: expected %s", results_seen, describe(exp_v));
                $display("                    actual   %s", describe(act_v));
            end else begin
                $display("Result %0d arrived with nothing owed: %s", results_seen,
                         describe(act_v));
            end
        end
    endtask

    // Follow every transaction on the three channels at each rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_tint   = 1'b0;
            ground_rgba = '0;
            tint_rgba   = '0;
            tint_on     = 1'b0;
            want_left   = '0;
            want_top    = '0;
            want_right  = '0;
            want_bottom = '0;
            forget_region();
            verdict_q.delete();
        end else begin
            // Register write transaction.
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    rtbc_pkg::CFG_CHECK_MODE:    mode_tint   = i_cfg_data[0];
                    rtbc_pkg::CFG_GROUND_COLOR:  ground_rgba = i_cfg_data;
                    rtbc_pkg::CFG_TINT_COLOR:    tint_rgba   = i_cfg_data;
                    rtbc_pkg::CFG_TINT_PRESENT:  tint_on     = i_cfg_data[0];
                    rtbc_pkg::CFG_EXPECT_LEFT:   want_left   = i_cfg_data[COORD_BITS-1:0];
                    rtbc_pkg::CFG_EXPECT_TOP:    want_top    = i_cfg_data[COORD_BITS-1:0];
                    rtbc_pkg::CFG_EXPECT_RIGHT:  want_right  = i_cfg_data[COORD_BITS:0];
                    rtbc_pkg::CFG_EXPECT_BOTTOM: want_bottom = i_cfg_data[COORD_BITS:0];
                    default: ;
                endcase
            end
            // Result transaction; it is matched before this edge's pixel is
            // folded in, so a stray result never pairs with a fresh region.
            if (i_m_tvalid && i_m_tready) begin
                got.left        = i_m_tdata[0 +: COORD_BITS];
                got.top         = i_m_tdata[COORD_BITS +: COORD_BITS];
                got.right       = i_m_tdata[2*COORD_BITS +: COORD_BITS+1];
                got.bottom      = i_m_tdata[3*COORD_BITS+1 +: COORD_BITS+1];
                got.color       = i_m_tdata[4*COORD_BITS+2 +: 32];
                got.finding     = rtbc_pkg::t_finding'(i_m_tuser[2:0]);
                got.box_valid   = i_m_tuser[3];
                got.color_valid = i_m_tuser[4];
                results_seen++;
                kinds_seen[i_m_tuser[2:0]] = 1'b1;
                if (verdict_q.size() == 0) begin
                    report_result(1'b0, '0, got);
                end else begin
                    want = verdict_q.pop_front();
                    if (got !== want) begin
                        report_result(1'b1, want, got);
                    end
                end
            end
            // Pixel transaction.
            if (i_s_tvalid && i_s_tready) begin
                if (take_pixel(i_s_tdata[0 +: COORD_BITS],
                               i_s_tdata[COORD_BITS +: COORD_BITS],
                               i_s_tdata[2*COORD_BITS +: 32], i_s_tlast, fresh)) begin
                    verdict_q.push_back(fresh);
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= verdict_q.size();
        o_results    <= results_seen;
        o_kinds      <= kinds_seen;
    end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Region tint and bounds checker testbench
// Drives regions of pixels and register settings into the block, stalls the
// result side on changing patterns, and lets the result checker judge every
// result transaction. A directed opening covers the corner cases, then random
// settings each carry a batch of mostly raster-ordered regions.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CB          = rtbc_pkg::COORD_BITS;
    localparam int IN_W        = ((2*CB+32+7)/8)*8;
    localparam int OUT_W       = ((4*CB+34+7)/8)*8;
    localparam int MAX_COORD   = (1 << CB) - 1;
    localparam int RANDOM_PIX  = 1850;
    localparam int CYCLE_LIMIT = 400000;

    // Stall patterns of the result receiver.
    typedef enum int {RX_OPEN, RX_LIGHT, RX_PERIODIC, RX_HEAVY} t_rx_pattern;

    // Kinds of pixel color the generator can make.
    typedef enum int {PIX_GROUND, PIX_TINT, PIX_BLEND, PIX_FOREIGN, PIX_RANDOM} t_pix_kind;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_s_tvalid = 1'b0;
    logic                               o_s_tready;
    logic [IN_W-1:0]                    i_s_tdata = '0;
    logic                               i_s_tlast = 1'b0;
    logic                               o_m_tvalid;
    logic                               i_m_tready = 1'b0;
    logic [OUT_W-1:0]                   o_m_tdata;
    logic [rtbc_pkg::OUT_USER_BITS-1:0] o_m_tuser;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [rtbc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [rtbc_pkg::CFG_DATA_BITS-1:0] i_cfg_data = '0;

    int         fail_count;
    int         pending;
    int         results;
    logic [7:0] kinds;

    // Settings as last written, used by the pixel generator.
    logic        set_mode;
    logic [31:0] set_ground;
    logic [31:0] set_tint;
    int          set_left;
    int          set_top;
    int          set_right;
    int          set_bottom;

    int          pixels_sent = 0;
    int          regions_sent = 0;
    int          settings_used = 0;
    int          burst_left = 0;
    int          cycle_count = 0;
    t_rx_pattern rx_mode = RX_OPEN;
    int          rx_left = 0;

    region_tint_and_bounds_checker #(
        .COORD_BITS (CB)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    region_result_checker #(
        .COORD_BITS (CB)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tlast    (i_s_tlast),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_kinds      (kinds)
    );

    // Clock with a period of two time units.
    always #1 i_clk = ~i_clk;

    // Run-time guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result receiver: switches at random between stall patterns.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_pattern'($urandom_range(0, 3));
            rx_left <= $urandom_range(40, 300);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:     i_m_tready <= 1'b1;
            RX_LIGHT:    i_m_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: i_m_tready <= ((rx_left % 9) < 2);
            default:     i_m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Makes a pixel color of the requested kind for the current settings.
    function automatic logic [31:0] paint(input t_pix_kind kind);
        logic [31:0] rgba;
        logic [7:0]  g;
        logic [7:0]  t;
        logic [7:0]  lo;
        logic [7:0]  hi;
        int          k;
        int          k0;
        case (kind)
            PIX_GROUND: rgba = set_ground;
            PIX_TINT:   rgba = set_tint;
            PIX_RANDOM: begin
                rgba = $urandom;
                if (rgba == set_ground) rgba = ~rgba;
            end
            default: begin
                for (int c = 0; c < 4; c++) begin
                    g = set_ground[8*c +: 8];
                    t = set_tint[8*c +: 8];
                    lo = (g < t) ? g : t;
                    hi = (g < t) ? t : g;
                    rgba[8*c +: 8] = 8'($urandom_range(lo, hi));
                end
                // A foreign color pushes one channel outside its range, if any channel has room.
                if (kind == PIX_FOREIGN) begin
                    k0 = $urandom_range(0, 3);
                    for (int i = 0; i < 4; i++) begin
                        k  = (k0 + i) % 4;
                        g  = set_ground[8*k +: 8];
                        t  = set_tint[8*k +: 8];
                        lo = (g < t) ? g : t;
                        hi = (g < t) ? t : g;
                        if (lo > 0 && (hi == 8'hFF || $urandom_range(0, 1) == 0)) begin
                            rgba[8*k +: 8] = 8'($urandom_range(0, lo - 1));
                            break;
                        end else if (hi < 8'hFF) begin
                            rgba[8*k +: 8] = 8'($urandom_range(hi + 1, 255));
                            break;
                        end
                    end
                end
            end
        endcase
        return rgba;
    endfunction

    function automatic t_pix_kind choose_kind(input bit foreign_ok);
        int roll;
        roll = $urandom_range(0, 99);
        if (!foreign_ok) begin
            if (roll < 30) return PIX_GROUND;
            if (roll < 50) return PIX_TINT;
            return PIX_BLEND;
        end
        if (roll < 25) return PIX_GROUND;
        if (roll < 40) return PIX_TINT;
        if (roll < 85) return PIX_BLEND;
        if (roll < 95) return PIX_FOREIGN;
        return PIX_RANDOM;
    endfunction

    // Sends one pixel transaction, with random gaps between bursts.
    task automatic send_pixel(input int x, input int y, input logic [31:0] rgba,
                              input logic last);
        int gap;
        logic [CB-1:0] px;
        logic [CB-1:0] py;
        px = CB'(x);
        py = CB'(y);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_W'({rgba, py, px});
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        pixels_sent++;
        if (last) regions_sent++;
    endtask

    // Holds the pixel stream until every owed result has come, then lets the
    // pipeline run empty.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input rtbc_pkg::t_cfg_idx idx, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Writes every register; the block must be idle.
    task automatic set_all(input logic mode, input logic [31:0] ground,
                           input logic [31:0] tint, input logic present,
                           input int left, input int top, input int right, input int bottom);
        set_mode   = mode;
        set_ground = ground;
        set_tint   = tint;
        set_left   = left;
        set_top    = top;
        set_right  = right;
        set_bottom = bottom;
        cfg_write(rtbc_pkg::CFG_CHECK_MODE, 32'(mode));
        cfg_write(rtbc_pkg::CFG_GROUND_COLOR, ground);
        cfg_write(rtbc_pkg::CFG_TINT_COLOR, tint);
        cfg_write(rtbc_pkg::CFG_TINT_PRESENT, 32'(present));
        cfg_write(rtbc_pkg::CFG_EXPECT_LEFT, 32'(left));
        cfg_write(rtbc_pkg::CFG_EXPECT_TOP, 32'(top));
        cfg_write(rtbc_pkg::CFG_EXPECT_RIGHT, 32'(right));
        cfg_write(rtbc_pkg::CFG_EXPECT_BOTTOM, 32'(bottom));
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Sends a rectangle in raster order. In bounds mode the expected
    // rectangle is mostly painted and the rest mostly ground.
    task automatic send_raster(input int x0, input int y0, input int w, input int h,
                               input bit foreign_ok);
        logic [31:0] rgba;
        bit          in_rect;
        int          x;
        int          y;
        for (int row = 0; row < h; row++) begin
            for (int col = 0; col < w; col++) begin
                x = x0 + col;
                y = y0 + row;
                if (set_mode) begin
                    rgba = paint(choose_kind(foreign_ok));
                end else begin
                    in_rect = (x >= set_left && x < set_right && y >= set_top
                               && y < set_bottom);
                    if ($urandom_range(0, 99) < (in_rect ? 88 : 8)) begin
                        rgba = paint(PIX_RANDOM);
                    end else begin
                        rgba = paint(PIX_GROUND);
                    end
                end
                send_pixel(x, y, rgba, (row == h - 1) && (col == w - 1));
            end
        end
    endtask

    // Picks a start coordinate so that a span of the given size fits,
    // leaning toward both frame edges.
    function automatic int pick_start(input int span);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return 0;
        if (roll < 25) return MAX_COORD + 1 - span;
        return $urandom_range(0, MAX_COORD + 1 - span);
    endfunction

    // Main stimulus.
    initial begin
        logic [31:0] ground;
        logic [31:0] tint;
        int          w;
        int          h;
        int          l;
        int          t;
        int          r;
        int          b;
        int          x0;
        int          y0;
        int          x1;
        int          y1;
        int          n;
        int          roll;
        int          budget;
        int          random_goal;

        set_mode   = 1'b0;
        set_ground = '0;
        set_tint   = '0;
        set_left   = 0;
        set_top    = 0;
        set_right  = 0;
        set_bottom = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers at reset: bounds mode on a zero ground, nothing painted.
        send_pixel(0, 0, 32'h0000_0000, 1'b1);
        settle();

        // Far frame corner fills the expected box up to the exclusive edge.
        set_all(1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0,
                MAX_COORD, MAX_COORD, MAX_COORD + 1, MAX_COORD + 1);
        send_pixel(MAX_COORD, MAX_COORD, 32'hFFFF_FFFF, 1'b1);
        send_pixel(0, 0, 32'h0000_0001, 1'b1);
        settle();

        // Pixels out of raster order still count toward the box.
        set_all(1'b0, 32'h1122_3344, 32'h0000_0000, 1'b0, 2, 1, 10, 8);
        send_pixel(5, 5, 32'h0000_0000, 1'b0);
        send_pixel(2, 7, 32'h0000_0055, 1'b0);
        send_pixel(9, 1, 32'h0000_00AA, 1'b0);
        send_pixel(3, 3, 32'h1122_3344, 1'b0);
        send_pixel(7, 4, 32'h1122_3344, 1'b1);
        settle();

        // Tint mode without a configured tint.
        set_all(1'b1, 32'h0000_0000, 32'h8080_8080, 1'b0, 0, 0, 0, 0);
        send_pixel(1, 1, 32'h1234_5678, 1'b1);
        settle();

        // Tint mode: held, tint absent, foreign color first wins, empty region.
        set_all(1'b1, 32'h0000_0000, 32'h8080_8080, 1'b1, 0, 0, 0, 0);
        send_pixel(0, 0, 32'h4040_4040, 1'b0);
        send_pixel(1, 0, 32'h8080_8080, 1'b0);
        send_pixel(2, 0, 32'h0000_0000, 1'b1);
        send_pixel(3, 0, 32'h1020_3040, 1'b0);
        send_pixel(4, 0, 32'h0000_0000, 1'b1);
        send_pixel(0, 0, 32'h4040_4040, 1'b0);
        send_pixel(10, 3, 32'h8100_0000, 1'b0);
        send_pixel(11, 3, 32'hFF00_0000, 1'b0);
        send_pixel(20, 9, 32'h8080_8080, 1'b1);
        send_pixel(0, 0, 32'h0000_0000, 1'b0);
        send_pixel(1, 0, 32'h0000_0000, 1'b1);
        settle();

        // Tint below ground in every channel.
        set_all(1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 0, 0, 0, 0);
        send_pixel(7, 7, 32'h0000_0000, 1'b0);
        send_pixel(8, 7, 32'h7F7F_7F7F, 1'b1);
        settle();

        // Mode switched while a region is open: the mode at the last pixel rules.
        set_all(1'b1, 32'h0000_0000, 32'h8080_8080, 1'b1, 5, 6, 7, 8);
        send_pixel(5, 6, 32'h0000_00FF, 1'b0);
        send_pixel(6, 7, 32'h0000_0001, 1'b0);
        settle();
        set_mode = 1'b0;
        cfg_write(rtbc_pkg::CFG_CHECK_MODE, 32'(1'b0));
        i_cfg_valid <= 1'b0;
        send_pixel(4, 4, 32'h0000_0000, 1'b1);
        settle();

        // Inverted expected rectangle is compared edge by edge.
        set_all(1'b0, 32'h0000_0000, 32'h0000_0000, 1'b0, 10, 10, 5, 5);
        send_pixel(10, 10, 32'hFFFF_FFFF, 1'b1);
        settle();

        // Random settings, each with a batch of regions.
        random_goal = pixels_sent + RANDOM_PIX;
        while (pixels_sent < random_goal) begin
            case ($urandom_range(0, 5))
                0:       ground = 32'h0000_0000;
                1:       ground = 32'hFFFF_FFFF;
                default: ground = $urandom;
            endcase
            case ($urandom_range(0, 5))
                0:       tint = 32'hFFFF_FFFF;
                1:       tint = 32'h0000_0000;
                2:       tint = ground;
                default: tint = $urandom;
            endcase
            w = $urandom_range(1, 5);
            h = $urandom_range(1, 4);
            l = pick_start(w);
            t = pick_start(h);
            r = ($urandom_range(0, 11) == 0) ? $urandom_range(0, l) : l + w;
            b = ($urandom_range(0, 11) == 0) ? $urandom_range(0, t) : t + h;
            set_all(1'($urandom_range(0, 1)), ground, tint, $urandom_range(0, 4) != 0,
                    l, t, r, b);

            budget = pixels_sent + $urandom_range(20, 90);
            while (pixels_sent < budget) begin
                roll = $urandom_range(0, 99);
                if (roll < 12) begin
                    // Noise: scattered coordinates and colors.
                    n = $urandom_range(1, 8);
                    for (int i = 0; i < n; i++) begin
                        send_pixel($urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD),
                                   paint(set_mode ? choose_kind(1'b1) :
                                         t_pix_kind'($urandom_range(0, 1) ? PIX_GROUND
                                                                          : PIX_RANDOM)),
                                   i == n - 1);
                    end
                end else if (!set_mode && roll < 80 && set_left < set_right
                             && set_top < set_bottom) begin
                    // Region around the expected rectangle with a thin margin.
                    x0 = set_left - $urandom_range(0, 1);
                    y0 = set_top - $urandom_range(0, 1);
                    x1 = set_right - 1 + $urandom_range(0, 1);
                    y1 = set_bottom - 1 + $urandom_range(0, 1);
                    if (x0 < 0) x0 = 0;
                    if (y0 < 0) y0 = 0;
                    if (x1 > MAX_COORD) x1 = MAX_COORD;
                    if (y1 > MAX_COORD) y1 = MAX_COORD;
                    send_raster(x0, y0, x1 - x0 + 1, y1 - y0 + 1, 1'b0);
                end else begin
                    w = $urandom_range(1, 5);
                    h = $urandom_range(1, 4);
                    send_raster(pick_start(w), pick_start(h), w, h,
                                $urandom_range(0, 9) < 3);
                end
                // Now and then the sender waits for every result to come back.
                if (roll == 99) begin
                    settle();
                end
            end
            settle();
        end

        $display("Run covered %0d pixels in %0d regions under %0d register settings.",
                 pixels_sent, regions_sent, settings_used);
        $display("Results checked: %0d; finding codes seen (bit per code): %b",
                 results, kinds);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: region_tint_and_bounds_checker.f
sv/rtbc_pkg.sv
sv/rtbc_front.sv
sv/rtbc_queue.sv
sv/rtbc_back.sv
sv/region_tint_and_bounds_checker.sv
sim/region_result_checker.sv
sim/testbench.sv
